// ===== design/fsc_pkg.sv =====
// Shared types, constants and a helper function for the stack processor core.
`default_nettype none
package fsc_pkg;

    // Word memory geometry: indices always wrap to fifteen bits.
    localparam int ADDR_W    = 15;
    localparam int DATA_W    = 16;
    localparam int MEM_WORDS = 1 << ADDR_W;

    // Reset values of the stack pointers.
    localparam logic [ADDR_W-1:0] DSP_RESET = 15'd8704;
    localparam logic [ADDR_W-1:0] RSP_RESET = 15'd32767;

    // Trap taken on a divide by zero.
    localparam logic [ADDR_W-1:0] DIV0_PC  = 15'd1;
    localparam logic [DATA_W-1:0] DIV0_TOS = 16'd10;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_EXEC  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Result status codes.
    localparam logic [1:0] ST_EXECUTED = 2'd0;
    localparam logic [1:0] ST_STALLED  = 2'd1;
    localparam logic [1:0] ST_HALTED   = 2'd2;
    localparam logic [1:0] ST_MEM_DONE = 2'd3;

    // Instruction classes.
    typedef enum logic [2:0] {
        KIND_LIT,
        KIND_ALU,
        KIND_CALL,
        KIND_CBRANCH,
        KIND_BRANCH
    } ins_kind_t;

    // ALU function codes (bits 12:8 of an ALU instruction).
    typedef logic [4:0] alu_fn_t;
    localparam alu_fn_t FN_N     = 5'd1;
    localparam alu_fn_t FN_R     = 5'd2;
    localparam alu_fn_t FN_FETCH = 5'd3;
    localparam alu_fn_t FN_STORE = 5'd4;
    localparam alu_fn_t FN_ADDC  = 5'd5;
    localparam alu_fn_t FN_MULH  = 5'd6;
    localparam alu_fn_t FN_AND   = 5'd7;
    localparam alu_fn_t FN_OR    = 5'd8;
    localparam alu_fn_t FN_XOR   = 5'd9;
    localparam alu_fn_t FN_INV   = 5'd10;
    localparam alu_fn_t FN_DEC   = 5'd11;
    localparam alu_fn_t FN_ZEQ   = 5'd12;
    localparam alu_fn_t FN_EQ    = 5'd13;
    localparam alu_fn_t FN_ULT   = 5'd14;
    localparam alu_fn_t FN_LT    = 5'd15;
    localparam alu_fn_t FN_RSH   = 5'd16;
    localparam alu_fn_t FN_LSH   = 5'd17;
    localparam alu_fn_t FN_SP    = 5'd18;
    localparam alu_fn_t FN_RP    = 5'd19;
    localparam alu_fn_t FN_SETSP = 5'd20;
    localparam alu_fn_t FN_SETRP = 5'd21;
    localparam alu_fn_t FN_ZERO  = 5'd22;
    localparam alu_fn_t FN_OUT   = 5'd23;
    localparam alu_fn_t FN_IN    = 5'd24;
    localparam alu_fn_t FN_UDIV  = 5'd25;
    localparam alu_fn_t FN_SDIV  = 5'd26;
    localparam alu_fn_t FN_HALT  = 5'd27;

    // Memory address sources.
    typedef enum logic [2:0] {
        ADDR_REQ,
        ADDR_PC,
        ADDR_SP,
        ADDR_RP,
        ADDR_TOS,
        ADDR_SPW,
        ADDR_SPF,
        ADDR_RPF
    } addr_sel_t;

    // Memory write data sources.
    typedef enum logic [1:0] {
        WD_REQ,
        WD_NN,
        WD_TW,
        WD_CALL
    } wd_sel_t;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_MWR,
        S_MRD,
        S_MRD_WAIT,
        S_FETCH,
        S_RD_N,
        S_RD_R,
        S_RD_T,
        S_RD_W,
        S_EXEC,
        S_WR_LIT,
        S_WR_CALL,
        S_ST_TOS,
        S_LD4,
        S_LD4_WAIT,
        S_WR_LOW,
        S_DIV,
        S_WB_R,
        S_WB_N,
        S_COMMIT,
        S_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      ld_req;
        logic      mem_we;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        logic      ld_ins;
        logic      ld_n;
        logic      ld_r;
        logic      ld_tm;
        logic      ld_rd;
        logic      ld_exec;
        logic      ld_t4;
        logic      div_start;
        logic      ld_div;
        logic      commit;
        logic      ld_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t       op;
        ins_kind_t kind;
        alu_fn_t   fn;
        logic      wr_r;
        logic      wr_n;
        logic      stall;
        logic      halt;
        logic      div_zero;
        logic      div_done;
    } stat_t;

    // Stack pointer adjustment for a two-bit delta code: 0, +1, -2, -1.
    function automatic logic [ADDR_W-1:0] stack_delta(input logic [1:0] code);
        logic [ADDR_W-1:0] d;
        case (code)
            2'd0:    d = '0;
            2'd1:    d = ADDR_W'(1);
            2'd2:    d = ADDR_W'(-2);
            default: d = ADDR_W'(-1);
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== design/fsc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, signed or unsigned.
`default_nettype none
module fsc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic                      signed_op,
    input  wire logic [fsc_pkg::DATA_W-1:0] dividend,
    input  wire logic [fsc_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [fsc_pkg::DATA_W-1:0]     quotient,
    output logic [fsc_pkg::DATA_W-1:0]     remainder
);
    localparam int CNT_W = $clog2(fsc_pkg::DATA_W + 1);

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [fsc_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [fsc_pkg::DATA_W-1:0] quo_reg, quo_next;
    logic [fsc_pkg::DATA_W-1:0] dvs_reg, dvs_next;
    logic                       neg_q_reg, neg_q_next;
    logic                       neg_r_reg, neg_r_next;

    logic                       dvd_neg, dvs_neg;
    logic [fsc_pkg::DATA_W:0]   trial;

    // Operand signs only matter for the signed form.
    assign dvd_neg = signed_op & dividend[fsc_pkg::DATA_W-1];
    assign dvs_neg = signed_op & divisor[fsc_pkg::DATA_W-1];

    // One trial subtraction of the shifted partial remainder.
    assign trial = {rem_reg, quo_reg[fsc_pkg::DATA_W-1]} - {1'b0, dvs_reg};

    always_comb begin
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        if (start) begin
            cnt_next   = CNT_W'(fsc_pkg::DATA_W);
            rem_next   = '0;
            quo_next   = dvd_neg ? (~dividend + 1'b1) : dividend;
            dvs_next   = dvs_neg ? (~divisor + 1'b1) : divisor;
            neg_q_next = dvd_neg ^ dvs_neg;
            neg_r_next = dvd_neg;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[fsc_pkg::DATA_W]) begin
                rem_next = trial[fsc_pkg::DATA_W-1:0];
            end else begin
                rem_next = {rem_reg[fsc_pkg::DATA_W-2:0], quo_reg[fsc_pkg::DATA_W-1]};
            end
            quo_next = {quo_reg[fsc_pkg::DATA_W-2:0], ~trial[fsc_pkg::DATA_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // Truncating division: quotient sign from both operands, remainder from the dividend.
    assign done      = (cnt_reg == '0);
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule
`default_nettype wire

// ===== design/fsc_datapath.sv =====
// Datapath: word memory, machine registers, instruction decode, ALU and result register.
`default_nettype none
module fsc_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire fsc_pkg::cmd_t             cmd,
    output fsc_pkg::stat_t                 stat,
    input  wire logic [1:0]                s_operation,
    input  wire logic [fsc_pkg::ADDR_W-1:0] s_address,
    input  wire logic [fsc_pkg::DATA_W-1:0] s_write_data,
    input  wire logic                      s_in_valid,
    input  wire logic [7:0]                s_in_byte,
    input  wire logic                      s_out_ready,
    output logic [1:0]                     m_status,
    output logic [fsc_pkg::DATA_W-1:0]     m_read_data,
    output logic                           m_consumed_input,
    output logic                           m_out_valid,
    output logic [7:0]                     m_out_byte,
    output logic [fsc_pkg::DATA_W-1:0]     m_top_value,
    output logic [fsc_pkg::ADDR_W-1:0]     m_next_pc
);
    localparam int AW = fsc_pkg::ADDR_W;
    localparam int DW = fsc_pkg::DATA_W;

    // Word memory, single port with registered read data.
    logic [DW-1:0] mem [fsc_pkg::MEM_WORDS];
    logic [DW-1:0] mem_rdata_reg;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata;

    // Machine state.
    logic [AW-1:0] pc_reg, sp_reg, rp_reg;
    logic [DW-1:0] t_reg;

    // Latched request.
    fsc_pkg::op_t  req_op_reg;
    logic [AW-1:0] req_addr_reg;
    logic [DW-1:0] req_wdata_reg;
    logic          req_in_valid_reg;
    logic [7:0]    req_in_byte_reg;
    logic          req_out_ready_reg;

    // Operands gathered from memory.
    logic [DW-1:0] ins_reg, n_reg, r_reg, tm_reg, rd_reg;

    // Working values of the instruction in flight.
    logic [DW-1:0] tn_reg, tn_next;
    logic [DW-1:0] tw_reg, tw_next;
    logic [DW-1:0] nn_reg, nn_next;
    logic [AW-1:0] spw_reg, spw_next;
    logic [AW-1:0] rpw_reg, rpw_next;
    logic [AW-1:0] npc_reg, npc_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          res_consumed_reg, res_consumed_next;
    logic          res_ovalid_reg, res_ovalid_next;
    logic [7:0]    res_obyte_reg, res_obyte_next;

    // Result register.
    logic [1:0]    out_status_reg;
    logic [DW-1:0] out_rdata_reg;
    logic          out_consumed_reg;
    logic          out_ovalid_reg;
    logic [7:0]    out_obyte_reg;
    logic [DW-1:0] out_top_reg;
    logic [AW-1:0] out_pc_reg;

    // Decode.
    fsc_pkg::ins_kind_t kind;
    fsc_pkg::alu_fn_t   fn;
    logic               is_alu;
    logic               stall, halt;
    logic [AW-1:0]      pc_inc, sp_fin, rp_fin;
    logic [DW:0]        sum;
    logic [2*DW-1:0]    prod;
    logic               div_done;
    logic [DW-1:0]      quotient, remainder;

    always_comb begin
        if (ins_reg[15]) begin
            kind = fsc_pkg::KIND_LIT;
        end else if (ins_reg[14:13] == 2'b11) begin
            kind = fsc_pkg::KIND_ALU;
        end else if (ins_reg[14]) begin
            kind = fsc_pkg::KIND_CALL;
        end else if (ins_reg[13]) begin
            kind = fsc_pkg::KIND_CBRANCH;
        end else begin
            kind = fsc_pkg::KIND_BRANCH;
        end
    end

    assign fn     = ins_reg[12:8];
    assign is_alu = (kind == fsc_pkg::KIND_ALU);
    assign stall  = is_alu && (((fn == fsc_pkg::FN_OUT) && !req_out_ready_reg)
                            || ((fn == fsc_pkg::FN_IN) && !req_in_valid_reg));
    assign halt   = is_alu && (fn == fsc_pkg::FN_HALT);
    assign pc_inc = pc_reg + 1'b1;

    // Final pointers: ALU instructions add the data stack delta and subtract the return stack delta.
    assign sp_fin = is_alu ? (spw_reg + fsc_pkg::stack_delta(ins_reg[1:0])) : spw_reg;
    assign rp_fin = is_alu ? (rpw_reg - fsc_pkg::stack_delta(ins_reg[3:2])) : rpw_reg;

    assign stat.op       = req_op_reg;
    assign stat.kind     = kind;
    assign stat.fn       = fn;
    assign stat.wr_r     = ins_reg[6];
    assign stat.wr_n     = ins_reg[7];
    assign stat.stall    = stall;
    assign stat.halt     = halt;
    assign stat.div_zero = (t_reg == '0);
    assign stat.div_done = div_done;

    // Address and write data selection.
    always_comb begin
        case (cmd.addr_sel)
            fsc_pkg::ADDR_REQ: mem_addr = req_addr_reg;
            fsc_pkg::ADDR_PC:  mem_addr = pc_reg;
            fsc_pkg::ADDR_SP:  mem_addr = sp_reg;
            fsc_pkg::ADDR_RP:  mem_addr = rp_reg;
            fsc_pkg::ADDR_TOS: mem_addr = t_reg[DW-1:1];
            fsc_pkg::ADDR_SPW: mem_addr = spw_reg;
            fsc_pkg::ADDR_SPF: mem_addr = sp_fin;
            fsc_pkg::ADDR_RPF: mem_addr = rp_fin;
            default:           mem_addr = pc_reg;
        endcase
        case (cmd.wd_sel)
            fsc_pkg::WD_REQ:  mem_wdata = req_wdata_reg;
            fsc_pkg::WD_NN:   mem_wdata = nn_reg;
            fsc_pkg::WD_TW:   mem_wdata = tw_reg;
            fsc_pkg::WD_CALL: mem_wdata = {pc_inc, 1'b0};
            default:          mem_wdata = tw_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    assign sum  = {1'b0, t_reg} + {1'b0, n_reg};
    assign prod = t_reg * n_reg;

    // Execute step: work out every value the instruction produces.
    always_comb begin
        tn_next           = t_reg;
        tw_next           = t_reg;
        nn_next           = n_reg;
        spw_next          = sp_reg;
        rpw_next          = rp_reg;
        npc_next          = pc_inc;
        res_consumed_next = 1'b0;
        res_ovalid_next   = 1'b0;
        res_obyte_next    = 8'd0;
        res_status_next   = stall ? fsc_pkg::ST_STALLED
                          : (halt ? fsc_pkg::ST_HALTED : fsc_pkg::ST_EXECUTED);
        case (kind)
            fsc_pkg::KIND_LIT: begin
                spw_next = sp_reg + 1'b1;
                tn_next  = {1'b0, ins_reg[14:0]};
            end
            fsc_pkg::KIND_CALL: begin
                rpw_next = rp_reg - 1'b1;
                npc_next = AW'(ins_reg[12:0]);
            end
            fsc_pkg::KIND_CBRANCH: begin
                npc_next = (t_reg == '0) ? AW'(ins_reg[12:0]) : pc_inc;
                tn_next  = n_reg;
                spw_next = sp_reg - 1'b1;
            end
            fsc_pkg::KIND_BRANCH: begin
                npc_next = AW'(ins_reg[12:0]);
            end
            fsc_pkg::KIND_ALU: begin
                npc_next = ins_reg[4] ? r_reg[DW-1:1] : pc_inc;
                case (fn)
                    fsc_pkg::FN_N:     tn_next = n_reg;
                    fsc_pkg::FN_R:     tn_next = r_reg;
                    fsc_pkg::FN_FETCH: tn_next = tm_reg;
                    fsc_pkg::FN_STORE: spw_next = sp_reg - 1'b1;
                    fsc_pkg::FN_ADDC: begin
                        tn_next = DW'(sum[DW]);
                        nn_next = sum[DW-1:0];
                    end
                    fsc_pkg::FN_MULH: begin
                        tn_next = prod[2*DW-1:DW];
                        nn_next = prod[DW-1:0];
                    end
                    fsc_pkg::FN_AND:   tn_next = t_reg & n_reg;
                    fsc_pkg::FN_OR:    tn_next = t_reg | n_reg;
                    fsc_pkg::FN_XOR:   tn_next = t_reg ^ n_reg;
                    fsc_pkg::FN_INV:   tn_next = ~t_reg;
                    fsc_pkg::FN_DEC:   tn_next = t_reg - 1'b1;
                    fsc_pkg::FN_ZEQ:   tn_next = {DW{t_reg == '0}};
                    fsc_pkg::FN_EQ:    tn_next = {DW{t_reg == n_reg}};
                    fsc_pkg::FN_ULT:   tn_next = {DW{n_reg < t_reg}};
                    fsc_pkg::FN_LT:    tn_next = {DW{$signed(n_reg) < $signed(t_reg)}};
                    fsc_pkg::FN_RSH:
                        tn_next = (t_reg[DW-1:4] == '0) ? (n_reg >> t_reg[3:0]) : '0;
                    fsc_pkg::FN_LSH:
                        tn_next = (t_reg[DW-1:4] == '0) ? (n_reg << t_reg[3:0]) : '0;
                    fsc_pkg::FN_SP:    tn_next = {sp_reg, 1'b0};
                    fsc_pkg::FN_RP:    tn_next = {rp_reg, 1'b0};
                    fsc_pkg::FN_SETSP: spw_next = t_reg[DW-1:1];
                    fsc_pkg::FN_SETRP: begin
                        rpw_next = t_reg[DW-1:1];
                        tn_next  = n_reg;
                    end
                    fsc_pkg::FN_ZERO:  tn_next = '0;
                    fsc_pkg::FN_OUT: begin
                        // The emitted byte comes from the top as it was before the step.
                        res_ovalid_next = req_out_ready_reg;
                        res_obyte_next  = req_out_ready_reg ? t_reg[7:0] : 8'd0;
                    end
                    fsc_pkg::FN_IN: begin
                        res_consumed_next = req_in_valid_reg;
                        tn_next           = {8'd0, req_in_byte_reg};
                    end
                    fsc_pkg::FN_UDIV, fsc_pkg::FN_SDIV: begin
                        if (t_reg == '0) begin
                            npc_next = fsc_pkg::DIV0_PC;
                            tn_next  = fsc_pkg::DIV0_TOS;
                        end
                    end
                    default: tn_next = t_reg;
                endcase
            end
            default: tn_next = t_reg;
        endcase
    end

    fsc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .signed_op (fn == fsc_pkg::FN_SDIV),
        .dividend  (n_reg),
        .divisor   (t_reg),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Machine state, updated only when an instruction commits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
            t_reg  <= '0;
            sp_reg <= fsc_pkg::DSP_RESET;
            rp_reg <= fsc_pkg::RSP_RESET;
        end else if (cmd.commit) begin
            pc_reg <= npc_reg;
            if (!halt) begin
                t_reg  <= (is_alu && ins_reg[5]) ? nn_reg : tn_reg;
                sp_reg <= sp_fin;
                rp_reg <= rp_fin;
            end
        end
    end

    // Request capture, operand capture and working registers.
    always_ff @(posedge aclk) begin
        if (cmd.ld_req) begin
            req_op_reg        <= fsc_pkg::op_t'(s_operation);
            req_addr_reg      <= s_address;
            req_wdata_reg     <= s_write_data;
            req_in_valid_reg  <= s_in_valid;
            req_in_byte_reg   <= s_in_byte;
            req_out_ready_reg <= s_out_ready;
        end
        if (cmd.ld_ins) ins_reg <= mem_rdata_reg;
        if (cmd.ld_n)   n_reg   <= mem_rdata_reg;
        if (cmd.ld_r)   r_reg   <= mem_rdata_reg;
        if (cmd.ld_tm)  tm_reg  <= mem_rdata_reg;
        if (cmd.ld_rd)  rd_reg  <= mem_rdata_reg;
        if (cmd.ld_exec) begin
            tn_reg           <= tn_next;
            tw_reg           <= tw_next;
            nn_reg           <= nn_next;
            spw_reg          <= spw_next;
            rpw_reg          <= rpw_next;
            npc_reg          <= npc_next;
            res_status_reg   <= res_status_next;
            res_consumed_reg <= res_consumed_next;
            res_ovalid_reg   <= res_ovalid_next;
            res_obyte_reg    <= res_obyte_next;
        end else if (cmd.ld_t4) begin
            tn_reg <= mem_rdata_reg;
        end else if (cmd.ld_div) begin
            tn_reg <= quotient;
            tw_reg <= remainder;
            nn_reg <= remainder;
        end
    end

    // Result register, loaded in the done state once the output side is free.
    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            if (req_op_reg == fsc_pkg::OP_EXEC) begin
                out_status_reg   <= res_status_reg;
                out_consumed_reg <= res_consumed_reg;
                out_ovalid_reg   <= res_ovalid_reg;
                out_obyte_reg    <= res_obyte_reg;
            end else begin
                out_status_reg   <= fsc_pkg::ST_MEM_DONE;
                out_consumed_reg <= 1'b0;
                out_ovalid_reg   <= 1'b0;
                out_obyte_reg    <= 8'd0;
            end
            out_rdata_reg <= (req_op_reg == fsc_pkg::OP_READ) ? rd_reg : '0;
            out_top_reg   <= t_reg;
            out_pc_reg    <= pc_reg;
        end
    end

    assign m_status         = out_status_reg;
    assign m_read_data      = out_rdata_reg;
    assign m_consumed_input = out_consumed_reg;
    assign m_out_valid      = out_ovalid_reg;
    assign m_out_byte       = out_obyte_reg;
    assign m_top_value      = out_top_reg;
    assign m_next_pc        = out_pc_reg;

endmodule
`default_nettype wire

// ===== design/fsc_ctrl.sv =====
// Controller: sequences memory accesses, execution, divide and result transfer.
`default_nettype none
module fsc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire fsc_pkg::stat_t stat,
    output fsc_pkg::cmd_t       cmd
);
    fsc_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign s_ready  = (state_reg == fsc_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fsc_pkg::S_IDLE: begin
                if (s_valid) state_next = fsc_pkg::S_FETCH;
            end
            fsc_pkg::S_FETCH: begin
                // First cycle after a transfer: dispatch on the latched operation.
                case (stat.op)
                    fsc_pkg::OP_WRITE: state_next = fsc_pkg::S_MWR;
                    fsc_pkg::OP_READ:  state_next = fsc_pkg::S_MRD;
                    fsc_pkg::OP_EXEC:  state_next = fsc_pkg::S_RD_N;
                    default:           state_next = fsc_pkg::S_DONE;
                endcase
            end
            fsc_pkg::S_MWR:      state_next = fsc_pkg::S_DONE;
            fsc_pkg::S_MRD:      state_next = fsc_pkg::S_MRD_WAIT;
            fsc_pkg::S_MRD_WAIT: state_next = fsc_pkg::S_DONE;
            fsc_pkg::S_RD_N:     state_next = fsc_pkg::S_RD_R;
            fsc_pkg::S_RD_R:     state_next = fsc_pkg::S_RD_T;
            fsc_pkg::S_RD_T:     state_next = fsc_pkg::S_RD_W;
            fsc_pkg::S_RD_W:     state_next = fsc_pkg::S_EXEC;
            fsc_pkg::S_EXEC: begin
                case (stat.kind)
                    fsc_pkg::KIND_LIT:  state_next = fsc_pkg::S_WR_LIT;
                    fsc_pkg::KIND_CALL: state_next = fsc_pkg::S_WR_CALL;
                    fsc_pkg::KIND_ALU: begin
                        if (stat.stall) begin
                            state_next = fsc_pkg::S_DONE;
                        end else if (stat.halt) begin
                            state_next = fsc_pkg::S_COMMIT;
                        end else begin
                            case (stat.fn)
                                fsc_pkg::FN_STORE: state_next = fsc_pkg::S_ST_TOS;
                                fsc_pkg::FN_ADDC, fsc_pkg::FN_MULH:
                                    state_next = fsc_pkg::S_WR_LOW;
                                fsc_pkg::FN_UDIV, fsc_pkg::FN_SDIV:
                                    state_next = stat.div_zero ? fsc_pkg::S_WB_R
                                                               : fsc_pkg::S_DIV;
                                default: state_next = fsc_pkg::S_WB_R;
                            endcase
                        end
                    end
                    default: state_next = fsc_pkg::S_COMMIT;
                endcase
            end
            fsc_pkg::S_WR_LIT:   state_next = fsc_pkg::S_COMMIT;
            fsc_pkg::S_WR_CALL:  state_next = fsc_pkg::S_COMMIT;
            fsc_pkg::S_ST_TOS:   state_next = fsc_pkg::S_LD4;
            fsc_pkg::S_LD4:      state_next = fsc_pkg::S_LD4_WAIT;
            fsc_pkg::S_LD4_WAIT: state_next = fsc_pkg::S_WB_R;
            fsc_pkg::S_WR_LOW:   state_next = fsc_pkg::S_WB_R;
            fsc_pkg::S_DIV: begin
                if (stat.div_done) state_next = fsc_pkg::S_WB_R;
            end
            fsc_pkg::S_WB_R:     state_next = fsc_pkg::S_WB_N;
            fsc_pkg::S_WB_N:     state_next = fsc_pkg::S_COMMIT;
            fsc_pkg::S_COMMIT:   state_next = fsc_pkg::S_DONE;
            fsc_pkg::S_DONE: begin
                if (out_free) state_next = fsc_pkg::S_IDLE;
            end
            default: state_next = fsc_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd           = '0;
        cmd.addr_sel  = fsc_pkg::ADDR_PC;
        cmd.wd_sel    = fsc_pkg::WD_TW;
        case (state_reg)
            fsc_pkg::S_IDLE: cmd.ld_req = s_valid;
            fsc_pkg::S_FETCH: cmd.addr_sel = fsc_pkg::ADDR_PC;
            fsc_pkg::S_MWR: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_REQ;
                cmd.wd_sel   = fsc_pkg::WD_REQ;
            end
            fsc_pkg::S_MRD:      cmd.addr_sel = fsc_pkg::ADDR_REQ;
            fsc_pkg::S_MRD_WAIT: cmd.ld_rd = 1'b1;
            fsc_pkg::S_RD_N: begin
                cmd.ld_ins   = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_SP;
            end
            fsc_pkg::S_RD_R: begin
                cmd.ld_n     = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_RP;
            end
            fsc_pkg::S_RD_T: begin
                cmd.ld_r     = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_TOS;
            end
            fsc_pkg::S_RD_W: cmd.ld_tm = 1'b1;
            fsc_pkg::S_EXEC: begin
                cmd.ld_exec   = 1'b1;
                cmd.div_start = (stat.kind == fsc_pkg::KIND_ALU) && !stat.div_zero
                             && ((stat.fn == fsc_pkg::FN_UDIV)
                              || (stat.fn == fsc_pkg::FN_SDIV));
            end
            fsc_pkg::S_WR_LIT: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_SPF;
                cmd.wd_sel   = fsc_pkg::WD_TW;
            end
            fsc_pkg::S_WR_CALL: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_RPF;
                cmd.wd_sel   = fsc_pkg::WD_CALL;
            end
            fsc_pkg::S_ST_TOS: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_TOS;
                cmd.wd_sel   = fsc_pkg::WD_NN;
            end
            fsc_pkg::S_LD4:      cmd.addr_sel = fsc_pkg::ADDR_SPW;
            fsc_pkg::S_LD4_WAIT: cmd.ld_t4 = 1'b1;
            fsc_pkg::S_WR_LOW: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fsc_pkg::ADDR_SP;
                cmd.wd_sel   = fsc_pkg::WD_NN;
            end
            fsc_pkg::S_DIV: cmd.ld_div = stat.div_done;
            fsc_pkg::S_WB_R: begin
                cmd.mem_we   = stat.wr_r;
                cmd.addr_sel = fsc_pkg::ADDR_RPF;
                cmd.wd_sel   = fsc_pkg::WD_TW;
            end
            fsc_pkg::S_WB_N: begin
                cmd.mem_we   = stat.wr_n;
                cmd.addr_sel = fsc_pkg::ADDR_SPF;
                cmd.wd_sel   = fsc_pkg::WD_TW;
            end
            fsc_pkg::S_COMMIT: cmd.commit = 1'b1;
            fsc_pkg::S_DONE:   cmd.ld_out = out_free;
            default:           cmd.ld_req = 1'b0;
        endcase
    end

    // Result valid flag: set when a result is loaded, cleared by its transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.ld_out)             m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fsc_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A transfer on the input always starts a new step.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == fsc_pkg::S_FETCH))
        else $error("accepted request did not start a step");

    // A result only appears after the final state of a step.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == fsc_pkg::S_DONE))
        else $error("result valid raised outside the done state");

    // The divider is never started against a zero divisor.
    a_no_div_by_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fsc_pkg::S_DIV) |-> !stat.div_zero)
        else $error("divide sequence entered with a zero divisor");

    // Memory writes never happen while waiting for a request.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fsc_pkg::S_IDLE) |-> !cmd.mem_we)
        else $error("memory write issued while idle");

endmodule
`default_nettype wire

// ===== design/forth_stack_cpu_core.sv =====
// A memory write or read passes the fetch state, its memory states and the done state; an
// instruction reads its operands and executes, then writes back and commits as it needs;
// a divide also waits for the one-bit-per-cycle divider. One request at a time: the next
// transfer is taken in the cycle after the result is loaded, even while that result waits.
// The single-port word memory sets this sequence: each operand and write-back has a state.
// Reset (aresetn low, synchronous) clears pc and top, sets pointers to 8704 and 32767.
`default_nettype none
module forth_stack_cpu_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_operation,
    input  wire logic [fsc_pkg::ADDR_W-1:0] s_address,
    input  wire logic [fsc_pkg::DATA_W-1:0] s_write_data,
    input  wire logic                      s_in_valid,
    input  wire logic [7:0]                s_in_byte,
    input  wire logic                      s_out_ready,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [1:0]                     m_status,
    output logic [fsc_pkg::DATA_W-1:0]     m_read_data,
    output logic                           m_consumed_input,
    output logic                           m_out_valid,
    output logic [7:0]                     m_out_byte,
    output logic [fsc_pkg::DATA_W-1:0]     m_top_value,
    output logic [fsc_pkg::ADDR_W-1:0]     m_next_pc
);
    fsc_pkg::cmd_t  cmd;
    fsc_pkg::stat_t stat;

    // Sequencer.
    fsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Memory, registers and arithmetic.
    fsc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_operation      (s_operation),
        .s_address        (s_address),
        .s_write_data     (s_write_data),
        .s_in_valid       (s_in_valid),
        .s_in_byte        (s_in_byte),
        .s_out_ready      (s_out_ready),
        .m_status         (m_status),
        .m_read_data      (m_read_data),
        .m_consumed_input (m_consumed_input),
        .m_out_valid      (m_out_valid),
        .m_out_byte       (m_out_byte),
        .m_top_value      (m_top_value),
        .m_next_pc        (m_next_pc)
    );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the stack processor core: drives and predicts its requests.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import fsc_pkg::*;

    // One expected or observed result transfer.
    typedef struct {
        logic [1:0]  status;
        logic [15:0] read_data;
        logic        consumed;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [15:0] top;
        logic [14:0] pc;
    } cpu_result_t;

    // Scoreboard: an architectural copy of the core and its queue of pending results.
    class stack_cpu_scoreboard;
        logic [15:0] mem [MEM_WORDS];
        logic [14:0] pc;
        logic [15:0] tos;
        logic [14:0] dsp;
        logic [14:0] rsp;
        cpu_result_t pending_results[$];
        int mismatches;
        int executed;
        int halts;
        int stalls;
        int div_traps;

        function new();
            pc = '0;
            tos = '0;
            dsp = DSP_RESET;
            rsp = RSP_RESET;
            mismatches = 0;
            executed = 0;
            halts = 0;
            stalls = 0;
            div_traps = 0;
        endfunction

        function logic [14:0] delta(input logic [1:0] code);
            logic [14:0] d;
            case (code)
                2'd0:    d = 15'd0;
                2'd1:    d = 15'd1;
                2'd2:    d = 15'h7FFE;
                default: d = 15'h7FFF;
            endcase
            return d;
        endfunction

        // Runs one instruction at the program counter against the state copy.
        function void step_cpu(input logic iv, input logic [7:0] ib, input logic oready,
                               inout cpu_result_t r);
            logic [15:0] ins, n, tn, t;
            logic [14:0] npc, p, sp, rp;
            logic [31:0] d;
            logic [16:0] ret;
            int sa, sb_, q, rem;
            logic stop;
            p = pc;
            t = tos;
            sp = dsp;
            rp = rsp;
            ins = mem[p];
            stop = 1'b0;
            if (ins[15]) begin
                sp = sp + 15'd1;
                mem[sp] = t;
                t = {1'b0, ins[14:0]};
                p = p + 15'd1;
            end else if (ins[15:13] == 3'b011) begin
                n = mem[sp];
                tn = t;
                npc = ins[4] ? mem[rp][15:1] : p + 15'd1;
                case (alu_fn_t'(ins[12:8]))
                    FN_N:     tn = n;
                    FN_R:     tn = mem[rp];
                    FN_FETCH: tn = mem[t[15:1]];
                    FN_STORE: begin
                        mem[t[15:1]] = n;
                        sp = sp - 15'd1;
                        tn = mem[sp];
                    end
                    FN_ADDC: begin
                        d = {16'd0, t} + {16'd0, n};
                        tn = d[31:16];
                        n = d[15:0];
                        mem[sp] = n;
                    end
                    FN_MULH: begin
                        d = {16'd0, t} * {16'd0, n};
                        tn = d[31:16];
                        n = d[15:0];
                        mem[sp] = n;
                    end
                    FN_AND:   tn = t & n;
                    FN_OR:    tn = t | n;
                    FN_XOR:   tn = t ^ n;
                    FN_INV:   tn = ~t;
                    FN_DEC:   tn = t - 16'd1;
                    FN_ZEQ:   tn = (t == 16'd0) ? 16'hFFFF : 16'd0;
                    FN_EQ:    tn = (t == n) ? 16'hFFFF : 16'd0;
                    FN_ULT:   tn = (n < t) ? 16'hFFFF : 16'd0;
                    FN_LT:    tn = ($signed(n) < $signed(t)) ? 16'hFFFF : 16'd0;
                    FN_RSH:   tn = (t < 16'd16) ? n >> t[3:0] : 16'd0;
                    FN_LSH:   tn = (t < 16'd16) ? n << t[3:0] : 16'd0;
                    FN_SP:    tn = {sp, 1'b0};
                    FN_RP:    tn = {rp, 1'b0};
                    FN_SETSP: sp = t[15:1];
                    FN_SETRP: begin
                        rp = t[15:1];
                        tn = n;
                    end
                    FN_ZERO:  tn = 16'd0;
                    FN_OUT: begin
                        if (!oready) begin
                            r.status = ST_STALLED;
                            stop = 1'b1;
                        end else begin
                            r.out_valid = 1'b1;
                            r.out_byte = t[7:0];
                        end
                    end
                    FN_IN: begin
                        if (!iv) begin
                            r.status = ST_STALLED;
                            stop = 1'b1;
                        end else begin
                            r.consumed = 1'b1;
                            tn = {8'd0, ib};
                        end
                    end
                    FN_UDIV: begin
                        if (t != 16'd0) begin
                            tn = n / t;
                            t = n % t;
                            n = t;
                        end else begin
                            npc = DIV0_PC;
                            tn = DIV0_TOS;
                            div_traps++;
                        end
                    end
                    FN_SDIV: begin
                        if (t != 16'd0) begin
                            sa = $signed(n);
                            sb_ = $signed(t);
                            q = sa / sb_;
                            rem = sa % sb_;
                            tn = q[15:0];
                            t = rem[15:0];
                            n = t;
                        end else begin
                            npc = DIV0_PC;
                            tn = DIV0_TOS;
                            div_traps++;
                        end
                    end
                    FN_HALT: begin
                        r.status = ST_HALTED;
                        p = npc;
                        stop = 1'b1;
                        halts++;
                    end
                    default: ;
                endcase
                if (stop && r.status == ST_STALLED) stalls++;
                if (!stop) begin
                    p = npc;
                    sp = sp + delta(ins[1:0]);
                    rp = rp - delta(ins[3:2]);
                    if (ins[5]) tn = n;
                    if (ins[6]) mem[rp] = t;
                    if (ins[7]) mem[sp] = t;
                    t = tn;
                end
            end else if (ins[14]) begin
                rp = rp - 15'd1;
                ret = {2'b0, p} + 17'd1;
                mem[rp] = {ret[14:0], 1'b0};
                p = {2'b0, ins[12:0]};
            end else if (ins[13]) begin
                p = (t == 16'd0) ? {2'b0, ins[12:0]} : p + 15'd1;
                t = mem[sp];
                sp = sp - 15'd1;
            end else begin
                p = {2'b0, ins[12:0]};
            end
            pc = p;
            tos = t;
            dsp = sp;
            rsp = rp;
            executed++;
        endfunction

        // Notes one accepted request and queues the result it should produce.
        function void note_request(input logic [1:0] op, input logic [14:0] addr,
                                   input logic [15:0] wd, input logic iv,
                                   input logic [7:0] ib, input logic oready);
            cpu_result_t r;
            r.status = ST_EXECUTED;
            r.read_data = '0;
            r.consumed = 1'b0;
            r.out_valid = 1'b0;
            r.out_byte = '0;
            case (op_t'(op))
                OP_WRITE: begin
                    mem[addr] = wd;
                    r.status = ST_MEM_DONE;
                end
                OP_READ: begin
                    r.read_data = mem[addr];
                    r.status = ST_MEM_DONE;
                end
                OP_NONE: r.status = ST_MEM_DONE;
                default: step_cpu(iv, ib, oready, r);
            endcase
            r.top = tos;
            r.pc = pc;
            pending_results.push_back(r);
        endfunction

        // Compares one result transfer with the oldest pending result.
        function void check_result(input cpu_result_t got);
            cpu_result_t exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result transfer with nothing pending");
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status || got.read_data !== exp.read_data ||
                got.consumed !== exp.consumed || got.out_valid !== exp.out_valid ||
                got.out_byte !== exp.out_byte || got.top !== exp.top ||
                got.pc !== exp.pc) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp st=%0d rd=%h ci=%b ov=%b ob=%h tos=%h pc=%h",
                             exp.status, exp.read_data, exp.consumed, exp.out_valid,
                             exp.out_byte, exp.top, exp.pc);
                    $display("          got st=%0d rd=%h ci=%b ov=%b ob=%h tos=%h pc=%h",
                             got.status, got.read_data, got.consumed, got.out_valid,
                             got.out_byte, got.top, got.pc);
                end
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEM_TARGET = 1100;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_operation;
    logic [ADDR_W-1:0] s_address;
    logic [DATA_W-1:0] s_write_data;
    logic s_in_valid;
    logic [7:0] s_in_byte;
    logic s_out_ready;
    logic m_valid;
    logic m_ready;
    logic [1:0] m_status;
    logic [DATA_W-1:0] m_read_data;
    logic m_consumed_input;
    logic m_out_valid;
    logic [7:0] m_out_byte;
    logic [DATA_W-1:0] m_top_value;
    logic [ADDR_W-1:0] m_next_pc;

    stack_cpu_scoreboard cpu_model = new();
    int results_seen;
    int idle_cycles;
    int items_sent;
    bit no_gaps;

    forth_stack_cpu_core i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_address(s_address),
        .s_write_data(s_write_data),
        .s_in_valid(s_in_valid),
        .s_in_byte(s_in_byte),
        .s_out_ready(s_out_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_data(m_read_data),
        .m_consumed_input(m_consumed_input),
        .m_out_valid(m_out_valid),
        .m_out_byte(m_out_byte),
        .m_top_value(m_top_value),
        .m_next_pc(m_next_pc)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 7));
    endfunction

    // Offers one request, waits for its transfer, then idles for the drawn gap.
    task send_request(input op_t op, input logic [14:0] addr, input logic [15:0] wd,
                      input logic iv, input logic [7:0] ib, input logic oready);
        int gap;
        s_valid <= 1'b1;
        s_operation <= op;
        s_address <= addr;
        s_write_data <= wd;
        s_in_valid <= iv;
        s_in_byte <= ib;
        s_out_ready <= oready;
        do @(posedge aclk); while (!s_ready);
        cpu_model.note_request(op, addr, wd, iv, ib, oready);
        items_sent++;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Gives a word a random value when it has never been written.
    task ensure_word(input logic [14:0] a);
        if ($isunknown(cpu_model.mem[a])) begin
            send_request(OP_WRITE, a, 16'($urandom), 1'b0, 8'd0, 1'b0);
        end
    endtask

    // Makes sure every word the next instruction may read holds a value.
    task ensure_operands();
        logic [14:0] sp_below;
        sp_below = cpu_model.dsp - 15'd1;
        ensure_word(cpu_model.pc);
        ensure_word(cpu_model.dsp);
        ensure_word(sp_below);
        ensure_word(cpu_model.rsp);
        ensure_word(cpu_model.tos[15:1]);
    endtask

    // Places an instruction at the program counter and executes it.
    task run_instruction(input logic [15:0] ins, input logic iv, input logic oready);
        send_request(OP_WRITE, cpu_model.pc, ins, 1'($urandom_range(0, 1)), 8'($urandom),
                     1'b1);
        ensure_operands();
        send_request(OP_EXEC, 15'($urandom), 16'($urandom), iv, 8'($urandom), oready);
    endtask

    function logic [15:0] alu_ins(input alu_fn_t fn, input logic [7:0] ctl);
        return {3'b011, fn, ctl};
    endfunction

    function logic [15:0] lit_ins(input logic [14:0] v);
        return {1'b1, v};
    endfunction

    function logic [15:0] random_ins();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return lit_ins(15'($urandom));
        if (pick < 80) return alu_ins(5'($urandom_range(0, 31)), 8'($urandom));
        if (pick < 87) return {3'b010, 13'($urandom)};
        if (pick < 94) return {3'b001, 13'($urandom)};
        return {3'b000, 13'($urandom)};
    endfunction

    // Result side: random back-pressure plus one long hold-off.
    initial begin
        cpu_result_t got;
        int gap;
        m_ready <= 1'b0;
        results_seen = 0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = (results_seen == 300) ? HOLD_OFF_CYCLES : draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.status = m_status;
            got.read_data = m_read_data;
            got.consumed = m_consumed_input;
            got.out_valid = m_out_valid;
            got.out_byte = m_out_byte;
            got.top = m_top_value;
            got.pc = m_next_pc;
            cpu_model.check_result(got);
            results_seen++;
        end
    end

    // Request side: reset, directed cases, random programs, drain.
    initial begin
        int pick;
        int iter;
        logic [14:0] addr;
        idle_cycles = 0;
        items_sent = 0;
        iter = 0;
        no_gaps = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_operation <= OP_NONE;
        s_address <= '0;
        s_write_data <= '0;
        s_in_valid <= 1'b0;
        s_in_byte <= '0;
        s_out_ready <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: address extremes, unused operation and the special instruction cases.
        send_request(OP_WRITE, 15'h7FFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
        send_request(OP_READ, 15'h7FFF, 16'h0000, 1'b0, 8'h00, 1'b0);
        send_request(OP_WRITE, 15'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
        send_request(OP_READ, 15'h0000, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
        send_request(OP_NONE, 15'h1234, 16'h5678, 1'b1, 8'h5A, 1'b1);
        run_instruction(lit_ins(15'h7FFF), 1'b0, 1'b0);
        run_instruction(lit_ins(15'h0000), 1'b0, 1'b0);
        // Unsigned divide by zero traps.
        run_instruction(alu_ins(FN_UDIV, 8'h03), 1'b0, 1'b0);
        // Most negative value divided by minus one.
        run_instruction(lit_ins(15'h4000), 1'b0, 1'b0);
        run_instruction(lit_ins(15'h0001), 1'b0, 1'b0);
        run_instruction(alu_ins(FN_LSH, 8'h03), 1'b0, 1'b0);
        run_instruction(lit_ins(15'h0000), 1'b0, 1'b0);
        run_instruction(alu_ins(FN_INV, 8'h00), 1'b0, 1'b0);
        run_instruction(alu_ins(FN_SDIV, 8'h03), 1'b0, 1'b0);
        // Shift by sixteen, stalls, halt and an unused function code.
        run_instruction(lit_ins(15'd16), 1'b0, 1'b0);
        run_instruction(alu_ins(FN_RSH, 8'h03), 1'b0, 1'b0);
        run_instruction(alu_ins(FN_IN, 8'h01), 1'b0, 1'b1);
        run_instruction(alu_ins(FN_OUT, 8'h03), 1'b1, 1'b0);
        run_instruction(alu_ins(FN_IN, 8'h01), 1'b1, 1'b1);
        run_instruction(alu_ins(FN_HALT, 8'h00), 1'b1, 1'b1);
        run_instruction(alu_ins(5'd28, 8'hFF), 1'b1, 1'b1);

        // Random part: mostly placed instructions, some raw execution and memory traffic.
        while (items_sent < ITEM_TARGET) begin
            if (iter % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            iter++;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                run_instruction(random_ins(), $urandom_range(0, 3) != 0,
                                $urandom_range(0, 3) != 0);
            end else if (pick < 80) begin
                ensure_operands();
                send_request(OP_EXEC, 15'($urandom), 16'($urandom), 1'($urandom),
                             8'($urandom), 1'($urandom));
            end else if (pick < 90) begin
                addr = 15'($urandom);
                ensure_word(addr);
                send_request(OP_READ, addr, 16'($urandom), 1'($urandom), 8'($urandom),
                             1'($urandom));
            end else if (pick < 95) begin
                send_request(OP_WRITE, 15'($urandom), 16'($urandom), 1'($urandom),
                             8'($urandom), 1'($urandom));
            end else begin
                send_request(OP_NONE, 15'($urandom), 16'($urandom), 1'($urandom),
                             8'($urandom), 1'($urandom));
            end
        end
        s_valid <= 1'b0;

        // Drain the outstanding results, then allow for the worst instruction latency.
        while (cpu_model.pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("run: %0d results checked, %0d instructions executed (%0d halts, %0d stalls)",
                 results_seen, cpu_model.executed, cpu_model.halts, cpu_model.stalls);
        $display("     %0d divide traps, %0d mismatches", cpu_model.div_traps,
                 cpu_model.mismatches);
        if (cpu_model.mismatches == 0 && cpu_model.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
design/fsc_pkg.sv
design/fsc_div.sv
design/fsc_datapath.sv
design/fsc_ctrl.sv
design/forth_stack_cpu_core.sv
verif/testbench.sv
